@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hw/rtl/fcsps_pkg.sv @@
// types and constants of the four channel servo pulse slewer
package fcsps_pkg;

   localparam int SERVO_COUNT_DEFAULT = 4;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CSR_IDX_SLOT_TICKS = 1'b0;
   localparam logic CSR_IDX_SPEED_MODE = 1'b1;

   localparam logic [9:0] SLOT_TICKS_RESET = 10'd500;
   localparam logic       SPEED_MODE_RESET = 1'b1;

   localparam logic [7:0] WIDTH_NOW_RESET  = 8'd149;
   localparam logic [7:0] WIDTH_GOAL_RESET = 8'd150;
   localparam logic [3:0] STEP_MASK_RESET  = 4'h3;
   localparam logic [3:0] FIXED_ADJ_MASK   = 4'h5;
   localparam logic [7:0] WIDTH_MAX        = 8'd255;
   localparam logic [7:0] WIDTH_MIN        = 8'd0;

   localparam logic [1:0] OP_TICK       = 2'd0;
   localparam logic [1:0] OP_SET_TARGET = 2'd1;
   localparam logic [1:0] OP_SET_MASK   = 2'd2;

   typedef struct packed {
      logic [1:0] opcode;
      logic [1:0] servo_index;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic [3:0] pins;
      logic [3:0] reached_mask;
      logic [1:0] active_servo;
   } rsp_type;

   typedef struct packed {
      logic [9:0] slot_ticks;
      logic       speed_mode;
   } cfg_type;

endpackage

@@ hw/rtl/four_channel_servo_pulse_slewer.sv @@
// top level: multiplexed servo pulse generator with width slewing
// Drives the servo pins one slot at a time; each tick transaction advances the slot timer
// by one 10 us tick and each set transaction updates a target or an adjust mask. One
// transaction is taken every cycle while the output is not stalled: it lands in an input
// register, the whole slot and slew update runs as combinational logic against the state
// registers, and its result sits in an output register; the sustained rate of one
// transaction per cycle is set by that state update loop, and a stalled output holds it.
`include "assert_macros.svh"

module four_channel_servo_pulse_slewer
   import fcsps_pkg::*;
#(
   parameter int SERVO_COUNT = SERVO_COUNT_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int SLOT_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SERVO_COUNT - 1);

   cfg_type cfg;

   fcsps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // handshake registers
   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   logic    out_free;
   logic    step;

   // servo state
   logic [7:0]        width_now_ff  [SERVO_COUNT];
   logic [7:0]        width_now_in  [SERVO_COUNT];
   logic [7:0]        width_goal_ff [SERVO_COUNT];
   logic [7:0]        width_goal_in [SERVO_COUNT];
   logic [3:0]        step_mask_ff  [SERVO_COUNT];
   logic [3:0]        step_mask_in  [SERVO_COUNT];
   logic [9:0]        slot_tick_ff;
   logic [9:0]        slot_tick_in;
   logic [SLOT_W-1:0] servo_slot_ff;
   logic [SLOT_W-1:0] servo_slot_in;
   logic [1:0]        frame_count_ff;
   logic [1:0]        frame_count_in;
   logic [SERVO_COUNT-1:0] reached_ff;
   logic [SERVO_COUNT-1:0] reached_in;
   logic              pulse_done_ff;
   logic              pulse_done_in;

   // datapath signals
   logic [7:0]             wn;
   logic [7:0]             goal;
   logic [3:0]             adj;
   logic [10:0]            tick_sum;
   logic                   last_tick;
   logic                   fire;
   logic                   below;
   logic [SERVO_COUNT-1:0] slot_bit;
   logic                   idx_ok;
   logic [SLOT_W-1:0]      idx_sel;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = out_free ? step : rsp_valid_ff;

   assign wn        = width_now_ff[servo_slot_ff];
   assign goal      = width_goal_ff[servo_slot_ff];
   assign adj       = cfg.speed_mode ? (4'b0001 << frame_count_ff) : FIXED_ADJ_MASK;
   assign tick_sum  = {1'b0, slot_tick_ff} + 11'd1;
   assign last_tick = tick_sum >= {1'b0, cfg.slot_ticks};
   assign below     = slot_tick_ff < {2'b00, wn};
   assign fire      = !pulse_done_ff && (!below || last_tick);
   assign slot_bit  = {{(SERVO_COUNT-1){1'b0}}, 1'b1} << servo_slot_ff;
   assign idx_ok    = 32'(in_data_ff.servo_index) < SERVO_COUNT;
   assign idx_sel   = SLOT_W'(in_data_ff.servo_index);

   always_comb begin
      width_now_in   = width_now_ff;
      width_goal_in  = width_goal_ff;
      step_mask_in   = step_mask_ff;
      slot_tick_in   = slot_tick_ff;
      servo_slot_in  = servo_slot_ff;
      frame_count_in = frame_count_ff;
      reached_in     = reached_ff;
      pulse_done_in  = pulse_done_ff;

      case (in_data_ff.opcode)
         OP_TICK: begin
            if (fire) begin
               pulse_done_in = 1'b1;
               if (wn == goal) begin
                  reached_in = reached_ff | slot_bit;
               end else if ((adj & step_mask_ff[servo_slot_ff]) != 4'b0000) begin
                  if (wn < goal) begin
                     if (wn != WIDTH_MAX) width_now_in[servo_slot_ff] = wn + 8'd1;
                  end else begin
                     if (wn != WIDTH_MIN) width_now_in[servo_slot_ff] = wn - 8'd1;
                  end
               end
            end
            if (last_tick) begin
               slot_tick_in  = '0;
               pulse_done_in = 1'b0;
               if (servo_slot_ff == LAST_SLOT) begin
                  servo_slot_in  = '0;
                  frame_count_in = frame_count_ff + 2'd1;
               end else begin
                  servo_slot_in = servo_slot_ff + SLOT_W'(1);
               end
            end else begin
               slot_tick_in = tick_sum[9:0];
            end
         end
         OP_SET_TARGET: begin
            if (idx_ok) begin
               width_goal_in[idx_sel] = in_data_ff.value;
               reached_in[idx_sel]    = 1'b0;
            end
         end
         OP_SET_MASK: begin
            if (idx_ok) step_mask_in[idx_sel] = in_data_ff.value[3:0];
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_data_in.pins         = below ? 4'(slot_bit) : 4'b0000;
      rsp_data_in.reached_mask = 4'(reached_in);
      rsp_data_in.active_servo = 2'(servo_slot_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_data_ff <= req_data;
      if (step) rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SERVO_COUNT; i++) begin
            width_now_ff[i]  <= WIDTH_NOW_RESET;
            width_goal_ff[i] <= WIDTH_GOAL_RESET;
            step_mask_ff[i]  <= STEP_MASK_RESET;
         end
         slot_tick_ff   <= '0;
         servo_slot_ff  <= '0;
         frame_count_ff <= '0;
         reached_ff     <= '0;
         pulse_done_ff  <= 1'b0;
      end else if (step) begin
         width_now_ff   <= width_now_in;
         width_goal_ff  <= width_goal_in;
         step_mask_ff   <= step_mask_in;
         slot_tick_ff   <= slot_tick_in;
         servo_slot_ff  <= servo_slot_in;
         frame_count_ff <= frame_count_in;
         reached_ff     <= reached_in;
         pulse_done_ff  <= pulse_done_in;
      end
   end

   // a reached servo sits at its goal until a new target clears the bit
   `ASSERT_IMPLY(a_reached_at_goal, clock, reset, reached_ff[servo_slot_ff],
                 width_now_ff[servo_slot_ff] == width_goal_ff[servo_slot_ff])
   `ASSERT_IMPLY(a_slot_in_range, clock, reset, 1'b1, 32'(servo_slot_ff) < SERVO_COUNT)
   `ASSERT_NEXT(a_slot_restart, clock, reset,
                step && in_data_ff.opcode == OP_TICK && last_tick,
                slot_tick_ff == 10'd0 && !pulse_done_ff)
   `ASSERT_NEXT(a_result_follows, clock, reset, step, rsp_valid_ff)

endmodule

@@ hw/rtl/fcsps_csr.sv @@
// configuration register file with apb-style access
module fcsps_csr
   import fcsps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [9:0] slot_ticks_ff;
   logic       speed_mode_ff;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ticks_ff <= SLOT_TICKS_RESET;
         speed_mode_ff <= SPEED_MODE_RESET;
      end else if (wr_en) begin
         case (paddr[2])
            CSR_IDX_SLOT_TICKS: slot_ticks_ff <= pwdata[9:0];
            CSR_IDX_SPEED_MODE: speed_mode_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_IDX_SLOT_TICKS: prdata = {{(CSR_DATA_W-10){1'b0}}, slot_ticks_ff};
         CSR_IDX_SPEED_MODE: prdata = {{(CSR_DATA_W-1){1'b0}}, speed_mode_ff};
         default:            prdata = '0;
      endcase
   end

   assign cfg.slot_ticks = slot_ticks_ff;
   assign cfg.speed_mode = speed_mode_ff;

endmodule
